// ===== sv/size_class_region_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SIZE_CLASS_REGION_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_REGION_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define SCRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scra: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SCRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scra: next-cycle check failed");

`else

`define SCRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/scra_pkg.sv =====
package scra_pkg;

  // Fixed geometry: the handle fields are 2 and 4 bits wide.
  localparam int NUM_CLASSES = 4;
  localparam int SLOTS       = 16;
  localparam int CLASS_W     = 2;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int SIZE_W      = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;

  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SIZE_W-1:0]  size_t;

  localparam count_t MAX_COUNT = count_t'(SLOTS);
  localparam size_t RESET_SIZE [NUM_CLASSES] = '{16'd64, 16'd256, 16'd1024, 16'd4096};

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NO_FIT      = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_CLASS_SIZE_0  = 3'd0,
    REG_CLASS_SIZE_1  = 3'd1,
    REG_CLASS_SIZE_2  = 3'd2,
    REG_CLASS_SIZE_3  = 3'd3,
    REG_CLASS_COUNT_0 = 3'd4,
    REG_CLASS_COUNT_1 = 3'd5,
    REG_CLASS_COUNT_2 = 3'd6,
    REG_CLASS_COUNT_3 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    opcode_t opcode;
    size_t   request_bytes;
    class_t  release_class;
    slot_t   release_slot;
  } req_t;

  typedef struct packed {
    status_t status;
    class_t  granted_class;
    slot_t   granted_slot;
    count_t  outstanding_count;
  } rsp_t;

  // Commands from the top level into one class lane.
  typedef struct packed {
    logic   refill;
    count_t count_val;
    logic   pop;
    logic   push;
    slot_t  push_slot;
  } lane_cmd_t;

  // Status of one class lane.
  typedef struct packed {
    slot_t  front_slot;
    count_t free_cnt;
    count_t outstanding;
    count_t count;
  } lane_stat_t;

  // Count registers saturate at the pool size.
  function automatic count_t sat_count(input count_t v);
    return (v > MAX_COUNT) ? MAX_COUNT : v;
  endfunction

endpackage

// ===== sv/scra_req_if.sv =====
interface scra_req_if;
  logic              valid;
  logic              ready;
  scra_pkg::req_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/scra_rsp_if.sv =====
interface scra_rsp_if;
  logic              valid;
  logic              ready;
  scra_pkg::rsp_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/scra_class_lane.sv =====
module scra_class_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scra_pkg::lane_cmd_t  cmd,
  output scra_pkg::lane_stat_t stat
);

  // Free list of one class, kept as a ring of slot numbers.
  scra_pkg::slot_t  ring_r [scra_pkg::SLOTS];
  scra_pkg::slot_t  head_r;
  scra_pkg::count_t free_r;
  scra_pkg::count_t outst_r;
  scra_pkg::count_t count_r;
  scra_pkg::slot_t  tail;

  // A released slot goes in right after the last free entry.
  assign tail = head_r + free_r[scra_pkg::SLOT_W-1:0];

  // Reset and refill load slots in order; otherwise pop from the head or push at the tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scra_pkg::SLOTS; i++) begin
        ring_r[i] <= scra_pkg::SLOT_W'(i);
      end
      head_r  <= '0;
      free_r  <= scra_pkg::MAX_COUNT;
      outst_r <= '0;
      count_r <= scra_pkg::MAX_COUNT;
    end else if (cmd.refill) begin
      for (int i = 0; i < scra_pkg::SLOTS; i++) begin
        ring_r[i] <= scra_pkg::SLOT_W'(i);
      end
      head_r  <= '0;
      free_r  <= cmd.count_val;
      outst_r <= '0;
      count_r <= cmd.count_val;
    end else if (cmd.pop) begin
      head_r  <= head_r + scra_pkg::SLOT_W'(1);
      free_r  <= free_r - scra_pkg::COUNT_W'(1);
      outst_r <= outst_r + scra_pkg::COUNT_W'(1);
    end else if (cmd.push) begin
      ring_r[tail] <= cmd.push_slot;
      free_r       <= free_r + scra_pkg::COUNT_W'(1);
      outst_r      <= outst_r - scra_pkg::COUNT_W'(1);
    end
  end

  assign stat.front_slot  = ring_r[head_r];
  assign stat.free_cnt    = free_r;
  assign stat.outstanding = outst_r;
  assign stat.count       = count_r;

endmodule

// ===== sv/size_class_region_allocator.sv =====
// A request word is held in the input register, then its result in the result register.
// A result not yet taken stalls the next word. The class scan is four parallel size compares.
// Throughput: one allocate or release per cycle while results are taken.
// Reset (rst_n low, synchronous): sizes 64/256/1024/4096, 16 slots per class,
// free lists in slot order, nothing outstanding, both pipeline registers empty.
`include "size_class_region_allocator_assert.svh"

module size_class_region_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  scra_req_if.sink                         in_if,
  scra_rsp_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scra_pkg::ADDR_W-1:0]      paddr,
  input  logic [scra_pkg::DATA_W-1:0]      pwdata,
  output logic [scra_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  logic                 in_vld_r;
  scra_pkg::req_t       req_r;
  logic                 out_vld_r;
  scra_pkg::rsp_t       rsp_r;
  scra_pkg::rsp_t       rsp_nxt;
  logic                 proc;
  logic                 cfg_wr;
  scra_pkg::reg_idx_t   reg_idx;
  scra_pkg::size_t      size_r [scra_pkg::NUM_CLASSES];
  scra_pkg::lane_cmd_t  lane_cmd [scra_pkg::NUM_CLASSES];
  scra_pkg::lane_stat_t lane_st [scra_pkg::NUM_CLASSES];
  logic [scra_pkg::NUM_CLASSES-1:0] fit;
  logic                 found;
  scra_pkg::class_t     sel;
  logic                 rel_ok;
  scra_pkg::count_t     cnt_val;

  // Handshakes: the input register refills whenever its word moves on.
  assign proc        = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || proc;
  assign out_if.valid   = out_vld_r;
  assign out_if.payload = rsp_r;

  // Configuration port decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = scra_pkg::reg_idx_t'(paddr[scra_pkg::ADDR_W-1:2]);
  assign cnt_val = scra_pkg::sat_count(pwdata[scra_pkg::COUNT_W-1:0]);

  // Class size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < scra_pkg::NUM_CLASSES; c++) begin
        size_r[c] <= scra_pkg::RESET_SIZE[c];
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        scra_pkg::REG_CLASS_SIZE_0: size_r[0] <= pwdata[scra_pkg::SIZE_W-1:0];
        scra_pkg::REG_CLASS_SIZE_1: size_r[1] <= pwdata[scra_pkg::SIZE_W-1:0];
        scra_pkg::REG_CLASS_SIZE_2: size_r[2] <= pwdata[scra_pkg::SIZE_W-1:0];
        scra_pkg::REG_CLASS_SIZE_3: size_r[3] <= pwdata[scra_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      scra_pkg::REG_CLASS_SIZE_0:  prdata = scra_pkg::DATA_W'(size_r[0]);
      scra_pkg::REG_CLASS_SIZE_1:  prdata = scra_pkg::DATA_W'(size_r[1]);
      scra_pkg::REG_CLASS_SIZE_2:  prdata = scra_pkg::DATA_W'(size_r[2]);
      scra_pkg::REG_CLASS_SIZE_3:  prdata = scra_pkg::DATA_W'(size_r[3]);
      scra_pkg::REG_CLASS_COUNT_0: prdata = scra_pkg::DATA_W'(lane_st[0].count);
      scra_pkg::REG_CLASS_COUNT_1: prdata = scra_pkg::DATA_W'(lane_st[1].count);
      scra_pkg::REG_CLASS_COUNT_2: prdata = scra_pkg::DATA_W'(lane_st[2].count);
      scra_pkg::REG_CLASS_COUNT_3: prdata = scra_pkg::DATA_W'(lane_st[3].count);
      default:                     prdata = '0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      req_r <= in_if.payload;
    end
  end

  // First class in order with a free slot and enough capacity.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int c = 0; c < scra_pkg::NUM_CLASSES; c++) begin
      fit[c] = (lane_st[c].free_cnt != '0) && (size_r[c] >= req_r.request_bytes);
      if (!found && fit[c]) begin
        found = 1'b1;
        sel   = scra_pkg::CLASS_W'(c);
      end
    end
  end

  assign rel_ok = ({1'b0, req_r.release_slot} < lane_st[req_r.release_class].count) &&
                  (lane_st[req_r.release_class].outstanding != '0);

  // Result word and lane commands.
  always_comb begin
    rsp_nxt = '{status: scra_pkg::ST_DONE, granted_class: '0, granted_slot: '0,
                outstanding_count: '0};
    for (int c = 0; c < scra_pkg::NUM_CLASSES; c++) begin
      lane_cmd[c]           = '0;
      lane_cmd[c].count_val = cnt_val;
      lane_cmd[c].push_slot = req_r.release_slot;
    end
    if (cfg_wr) begin
      unique case (reg_idx)
        scra_pkg::REG_CLASS_COUNT_0: lane_cmd[0].refill = 1'b1;
        scra_pkg::REG_CLASS_COUNT_1: lane_cmd[1].refill = 1'b1;
        scra_pkg::REG_CLASS_COUNT_2: lane_cmd[2].refill = 1'b1;
        scra_pkg::REG_CLASS_COUNT_3: lane_cmd[3].refill = 1'b1;
        default: ;
      endcase
    end
    if (req_r.opcode == scra_pkg::OP_ALLOC) begin
      if (found) begin
        rsp_nxt.granted_class     = sel;
        rsp_nxt.granted_slot      = lane_st[sel].front_slot;
        rsp_nxt.outstanding_count = lane_st[sel].outstanding + scra_pkg::COUNT_W'(1);
        lane_cmd[sel].pop         = proc;
      end else begin
        rsp_nxt.status = scra_pkg::ST_NO_FIT;
      end
    end else begin
      if (rel_ok) begin
        rsp_nxt.outstanding_count = lane_st[req_r.release_class].outstanding -
                                    scra_pkg::COUNT_W'(1);
        lane_cmd[req_r.release_class].push = proc;
      end else begin
        rsp_nxt.status            = scra_pkg::ST_BAD_RELEASE;
        rsp_nxt.outstanding_count = lane_st[req_r.release_class].outstanding;
      end
    end
  end

  // One lane per size class.
  for (genvar g = 0; g < scra_pkg::NUM_CLASSES; g++) begin : g_lane
    scra_class_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (lane_cmd[g]),
      .stat  (lane_st[g])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rsp_r <= rsp_nxt;
    end
  end

  // Checks: every region of a class is either free or outstanding.
  for (genvar g = 0; g < scra_pkg::NUM_CLASSES; g++) begin : g_chk
    `SCRA_ASSERT_IMP(a_lane_balance, clk, rst_n, 1'b1,
      ({1'b0, lane_st[g].free_cnt} + {1'b0, lane_st[g].outstanding}) ==
      {1'b0, lane_st[g].count})
  end

  `SCRA_ASSERT_NEXT(a_proc_result, clk, rst_n, proc, out_vld_r && (rsp_r == $past(rsp_nxt)))
  `SCRA_ASSERT_IMP(a_no_fit_empty, clk, rst_n,
    out_vld_r && (rsp_r.status == scra_pkg::ST_NO_FIT),
    (rsp_r.granted_class == '0) && (rsp_r.granted_slot == '0) &&
    (rsp_r.outstanding_count == '0))
  `SCRA_ASSERT_IMP(a_one_lane_cmd, clk, rst_n, 1'b1,
    $onehot0({lane_cmd[0].pop, lane_cmd[1].pop, lane_cmd[2].pop, lane_cmd[3].pop,
              lane_cmd[0].push, lane_cmd[1].push, lane_cmd[2].push, lane_cmd[3].push}))

endmodule

// ===== verif/size_class_region_allocator_tb.sv =====
module size_class_region_allocator_tb;
  import scra_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 460;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: either a request word or a register write.
  typedef struct {
    row_kind_t   kind;
    opcode_t     op;
    int unsigned bytes;
    int          cls;
    int          slot;
    bit          chk;
    status_t     st;
    int          gcls;
    int          gslot;
    int          outc;
    reg_idx_t    ridx;
    int unsigned rval;
  } dir_row_t;

  typedef struct packed {
    class_t cls;
    slot_t  slot;
  } handle_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  scra_req_if in_if ();
  scra_rsp_if out_if ();

  size_class_region_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the allocator state.
  size_t  cls_size  [NUM_CLASSES];
  count_t cls_count [NUM_CLASSES];
  slot_t  free_ring [NUM_CLASSES][SLOTS];
  slot_t  ring_head [NUM_CLASSES];
  count_t free_cnt  [NUM_CLASSES];
  count_t owed      [NUM_CLASSES];

  rsp_t    expected_grants [$];
  handle_t held_handles [$];
  dir_row_t dir_rows [$];
  rsp_t    head_w;

  int fault_count = 0;
  int words_sent = 0;
  int grants_seen = 0;
  int no_fit_seen = 0;
  int rejects_seen = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one row to the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Queue one expected result word behind the others.
  function automatic void expect_word(input rsp_t r);
    expected_grants.insert(expected_grants.size(), r);
  endfunction

  // Rebuild one class's free list in slot order.
  function automatic void refill_class(int c);
    int i;
    int k;
    for (i = 0; i < SLOTS; i++) free_ring[c][i] = slot_t'(i);
    ring_head[c] = '0;
    free_cnt[c] = cls_count[c];
    owed[c] = '0;
    for (k = held_handles.size() - 1; k >= 0; k--) begin
      if (held_handles[k].cls == class_t'(c)) held_handles.delete(k);
    end
  endfunction

  function automatic void reset_shadow();
    int c;
    for (c = 0; c < NUM_CLASSES; c++) begin
      cls_size[c] = RESET_SIZE[c];
      cls_count[c] = MAX_COUNT;
      refill_class(c);
    end
  endfunction

  // Register write as the block sees it; count writes saturate and refill.
  function automatic void apply_reg_write(reg_idx_t idx, logic [31:0] val);
    int c;
    count_t n;
    if (idx < REG_CLASS_COUNT_0) begin
      cls_size[idx] = val[15:0];
    end else begin
      c = int'(idx) - int'(REG_CLASS_COUNT_0);
      n = val[4:0];
      if (n > MAX_COUNT) n = MAX_COUNT;
      cls_count[c] = n;
      refill_class(c);
    end
  endfunction

  // Work out the result word for one request and advance the shadow state.
  function automatic rsp_t compute_grant(req_t w);
    rsp_t res;
    int c;
    int pos;
    bit hit;
    res.status = ST_DONE;
    res.granted_class = '0;
    res.granted_slot = '0;
    res.outstanding_count = '0;
    hit = 1'b0;
    if (w.opcode == OP_ALLOC) begin
      res.status = ST_NO_FIT;
      for (c = 0; c < NUM_CLASSES; c++) begin
        if (!hit && free_cnt[c] != 0 && cls_size[c] >= w.request_bytes) begin
          hit = 1'b1;
          res.status = ST_DONE;
          res.granted_class = class_t'(c);
          res.granted_slot = free_ring[c][ring_head[c]];
          ring_head[c] = ring_head[c] + 1'b1;
          free_cnt[c] = free_cnt[c] - 1'b1;
          owed[c] = owed[c] + 1'b1;
          res.outstanding_count = owed[c];
        end
      end
    end else begin
      c = w.release_class;
      if (w.release_slot >= cls_count[c] || owed[c] == 0) begin
        res.status = ST_BAD_RELEASE;
        res.outstanding_count = owed[c];
      end else begin
        pos = (int'(ring_head[c]) + int'(free_cnt[c])) % SLOTS;
        free_ring[c][pos] = w.release_slot;
        free_cnt[c] = free_cnt[c] + 1'b1;
        owed[c] = owed[c] - 1'b1;
        res.outstanding_count = owed[c];
      end
    end
    return res;
  endfunction

  // Mostly well-formed traffic: allocations at, under or one byte over a class size and
  // releases of held handles, with some raw noise mixed in.
  function automatic req_t next_random_word();
    req_t w;
    int unsigned pick;
    int c;
    int k;
    handle_t h;
    w.opcode = OP_ALLOC;
    w.request_bytes = size_t'($urandom_range(65535));
    w.release_class = class_t'($urandom_range(3));
    w.release_slot = slot_t'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 12) begin
      w.opcode = opcode_t'($urandom_range(1));
      return w;
    end
    if (held_handles.size() > 0 && (pick < 50 || held_handles.size() > 40)) begin
      k = $urandom_range(held_handles.size() - 1);
      h = held_handles[k];
      held_handles.delete(k);
      w.opcode = OP_RELEASE;
      w.release_class = h.cls;
      w.release_slot = h.slot;
      return w;
    end
    c = $urandom_range(NUM_CLASSES - 1);
    case ($urandom_range(3))
      0, 1: w.request_bytes = size_t'($urandom_range(cls_size[c]));
      2: w.request_bytes = cls_size[c];
      default: w.request_bytes = (cls_size[c] == 16'hFFFF) ? cls_size[c] : cls_size[c] + 1'b1;
    endcase
    return w;
  endfunction

  // Present one request word and record its expected result once accepted.
  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_exp);
    rsp_t got;
    handle_t h;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk); while (!in_if.ready);
    got = compute_grant(w);
    expect_word(typed ? typed_exp : got);
    if (w.opcode == OP_ALLOC && got.status == ST_DONE) begin
      h.cls = got.granted_class;
      h.slot = got.granted_slot;
      held_handles.insert(held_handles.size(), h);
    end
    words_sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase.
  task automatic program_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg_write(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Class setup for each random phase; the first restores the reset setup, the second pins the extremes.
  task automatic program_phase(input int p);
    logic [31:0] sz [NUM_CLASSES];
    logic [31:0] ct [NUM_CLASSES];
    int c;
    for (c = 0; c < NUM_CLASSES; c++) begin
      sz[c] = $urandom_range(65535) >> $urandom_range(12);
      if (sz[c] == 0) sz[c] = 1;
      ct[c] = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16);
    end
    case (p)
      0: begin
        sz = '{64, 256, 1024, 4096};
        ct = '{16, 16, 16, 16};
      end
      1: begin
        sz[0] = 1;
        sz[1] = 65535;
        ct = '{1, 0, 16, 31};
      end
      default: ;
    endcase
    for (c = 0; c < NUM_CLASSES; c++) begin
      program_reg(reg_idx_t'(c), sz[c]);
      program_reg(reg_idx_t'(NUM_CLASSES + c), ct[c]);
    end
  endtask

  // Receiver side: ready changes at the falling edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_grant(input rsp_t exp_w, input rsp_t got);
    if (got.status !== exp_w.status) begin
      $error("status: expected %0d, got %0d", exp_w.status, got.status);
      fault_count++;
    end
    if (got.granted_class !== exp_w.granted_class) begin
      $error("granted_class: expected %0d, got %0d", exp_w.granted_class, got.granted_class);
      fault_count++;
    end
    if (got.granted_slot !== exp_w.granted_slot) begin
      $error("granted_slot: expected %0d, got %0d", exp_w.granted_slot, got.granted_slot);
      fault_count++;
    end
    if (got.outstanding_count !== exp_w.outstanding_count) begin
      $error("outstanding_count: expected %0d, got %0d", exp_w.outstanding_count,
             got.outstanding_count);
      fault_count++;
    end
  endtask

  // Result monitor: every accepted word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_grants.size() == 0) begin
        $error("result word with nothing expected: status %0d", out_if.payload.status);
        fault_count++;
      end else begin
        head_w = expected_grants[0];
        expected_grants.delete(0);
        check_grant(head_w, out_if.payload);
        case (out_if.payload.status)
          ST_DONE: grants_seen++;
          ST_NO_FIT: no_fit_seen++;
          default: rejects_seen++;
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("size_class_region_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    int p;
    int i;
    dir_row_t row;
    req_t w;
    rsp_t typed_exp;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_shadow();

    // Directed table. Rows flagged 1'b1 carry a hand-written expectation.
    // Reset sizes: an exact fit, a zero-byte request, spill to the next class,
    // the largest class and no fit at all.
    add_row('{ROW_ITEM, OP_ALLOC, 64, 0, 0, 1'b1, ST_DONE, 0, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 0, 0, 0, 1'b1, ST_DONE, 0, 1, 2, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 65, 0, 0, 1'b1, ST_DONE, 1, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 4096, 0, 0, 1'b1, ST_DONE, 3, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 4097, 0, 0, 1'b1, ST_NO_FIT, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 65535, 3, 15, 1'b1, ST_NO_FIT, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    // Releases: a good one, one into a class with nothing out, a duplicate of a
    // slot that is still free, then a release after the class has drained.
    add_row('{ROW_ITEM, OP_RELEASE, 0, 0, 1, 1'b1, ST_DONE, 0, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 2, 0, 1'b1, ST_BAD_RELEASE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 3, 15, 1'b1, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 3, 0, 1'b1, ST_BAD_RELEASE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 1, 0, 1'b1, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 1, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    // Empty class 0, a one-slot class 1 of one byte, saturated counts on classes 2 and 3, class 3 at 65535 bytes.
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_COUNT_0, 0});
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_1, 1});
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_COUNT_1, 1});
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_COUNT_2, 31});
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_3, 65535});
    add_row('{ROW_CFG, OP_ALLOC, 0, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_COUNT_3, 17});
    add_row('{ROW_ITEM, OP_ALLOC, 1, 0, 0, 1'b1, ST_DONE, 1, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 1, 0, 0, 1'b1, ST_DONE, 2, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 1, 1, 1'b1, ST_BAD_RELEASE, 0, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 0, 0, 1'b1, ST_BAD_RELEASE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 65535, 0, 0, 1'b1, ST_DONE, 3, 0, 1, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_RELEASE, 0, 2, 15, 1'b1, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_0, 0});
    add_row('{ROW_ITEM, OP_ALLOC, 2, 0, 0, 1'b0, ST_DONE, 0, 0, 0, REG_CLASS_SIZE_0, 0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        program_reg(row.ridx, row.rval);
      end else begin
        w.opcode = row.op;
        w.request_bytes = size_t'(row.bytes);
        w.release_class = class_t'(row.cls);
        w.release_slot = slot_t'(row.slot);
        typed_exp = '{row.st, class_t'(row.gcls), slot_t'(row.gslot), count_t'(row.outc)};
        send_word(w, row.chk, typed_exp);
      end
    end

    // Random phases, each with its own class setup and pacing.
    for (p = 0; p < 4; p++) begin
      settle();
      program_phase(p);
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word(next_random_word(), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d request words over directed rows and four pacing phases.", words_sent);
    $display("Results: %0d grants or releases, %0d no-fit, %0d rejected releases.",
             grants_seen, no_fit_seen, rejects_seen);
    if (fault_count == 0 && expected_grants.size() == 0) begin
      $display("size_class_region_allocator: match");
    end else begin
      $display("size_class_region_allocator: mismatch");
    end
    $finish;
  end

endmodule
